@@ hw/rtl/ash_pkg.sv @@
// Package for the auxiliary security header parser.
// Holds the parse phase type, the control byte codes, the result bundle and the tag lookup.
// No dependencies.
package ash_pkg;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_COUNTER,
      PH_KEYSRC,
      PH_KEYIDX
   } phase_type;

   localparam int unsigned CounterBytes = 5;
   localparam int unsigned ShortSourceBytes = 2;
   localparam int unsigned LongSourceBytes = 8;

   localparam logic [1:0] MODE_DEFAULT = 2'd0;
   localparam logic [1:0] MODE_SHORT = 2'd2;

   localparam logic [7:0] IMPLIED_KEY_INDEX = 8'd1;

   typedef struct packed {
      logic [2:0]  security_level;
      logic [4:0]  tag_length;
      logic [1:0]  key_id_mode;
      logic        counter_suppressed;
      logic        counter_size_flag;
      logic [39:0] frame_counter;
      logic [63:0] key_source;
      logic [7:0]  key_index;
      logic [7:0]  total_header_length;
   } result_type;

   function automatic logic [4:0] tag_length_of(input logic [1:0] level_low);
      logic [4:0] len;
      unique case (level_low)
         2'd0: len = 5'd0;
         2'd1: len = 5'd4;
         2'd2: len = 5'd8;
         default: len = 5'd16;
      endcase
      return len;
   endfunction

endpackage

@@ hw/rtl/ash_parse.sv @@
// Parse state and per-byte update logic of the auxiliary security header parser.
// Holds the default key source register and builds a result on the closing byte.
// Depends on ash_pkg.
module ash_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [63:0]         csr_wr_data,
   input  logic                go,
   input  logic [7:0]          in_byte,
   input  logic                first_byte,
   input  logic [6:0]          header_offset,
   output logic                emit,
   output ash_pkg::result_type result
);

   ash_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [6:0]  ctrl_ff, ctrl_in;
   logic [39:0] counter_ff, counter_in;
   logic [63:0] keysrc_ff, keysrc_in;
   logic [7:0]  len_ff, len_in;
   logic [63:0] default_src_ff;
   logic [7:0]  key_index;
   logic [2:0]  src_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_src_ff <= '0;
      end else if (csr_wr_en) begin
         default_src_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ash_pkg::PH_IDLE;
         cnt_ff     <= '0;
         ctrl_ff    <= '0;
         counter_ff <= '0;
         keysrc_ff  <= '0;
         len_ff     <= '0;
      end else if (go) begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         ctrl_ff    <= ctrl_in;
         counter_ff <= counter_in;
         keysrc_ff  <= keysrc_in;
         len_ff     <= len_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      ctrl_in    = ctrl_ff;
      counter_in = counter_ff;
      keysrc_in  = keysrc_ff;
      len_in     = len_ff;
      emit       = 1'b0;
      key_index  = ash_pkg::IMPLIED_KEY_INDEX;
      src_last   = (ctrl_ff[4:3] == ash_pkg::MODE_SHORT) ?
                   3'(ash_pkg::ShortSourceBytes - 1) : 3'(ash_pkg::LongSourceBytes - 1);

      if (first_byte) begin
         ctrl_in    = in_byte[6:0];
         counter_in = '0;
         keysrc_in  = '0;
         cnt_in     = '0;
         len_in     = {1'b0, header_offset} + 8'd1;
         if (!in_byte[5]) begin
            phase_in = ash_pkg::PH_COUNTER;
         end else if (in_byte[4:3] == ash_pkg::MODE_DEFAULT) begin
            phase_in = ash_pkg::PH_IDLE;
            emit     = 1'b1;
         end else begin
            phase_in = ash_pkg::PH_KEYSRC;
         end
      end else begin
         unique case (phase_ff)
            ash_pkg::PH_COUNTER: begin
               for (int i = 0; i < 5; i++) begin
                  if (cnt_ff == 3'(i)) begin
                     counter_in[i*8 +: 8] = counter_ff[i*8 +: 8] | in_byte;
                  end
               end
               len_in = len_ff + 8'd1;
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff >= 3'(ash_pkg::CounterBytes - 1)) begin
                  cnt_in = '0;
                  if (ctrl_ff[4:3] == ash_pkg::MODE_DEFAULT) begin
                     phase_in = ash_pkg::PH_IDLE;
                     emit     = 1'b1;
                  end else begin
                     phase_in = ash_pkg::PH_KEYSRC;
                  end
               end
            end
            ash_pkg::PH_KEYSRC: begin
               for (int i = 0; i < 8; i++) begin
                  if (cnt_ff == 3'(i)) begin
                     keysrc_in[i*8 +: 8] = keysrc_ff[i*8 +: 8] | in_byte;
                  end
               end
               len_in = len_ff + 8'd1;
               if (cnt_ff >= src_last) begin
                  phase_in = ash_pkg::PH_KEYIDX;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            ash_pkg::PH_KEYIDX: begin
               len_in    = len_ff + 8'd1;
               key_index = in_byte;
               phase_in  = ash_pkg::PH_IDLE;
               cnt_in    = '0;
               emit      = 1'b1;
            end
            default: begin
            end
         endcase
      end

      result.security_level      = ctrl_in[2:0];
      result.tag_length          = ash_pkg::tag_length_of(ctrl_in[1:0]);
      result.key_id_mode         = ctrl_in[4:3];
      result.counter_suppressed  = ctrl_in[5];
      result.counter_size_flag   = ctrl_in[6];
      result.frame_counter       = ctrl_in[5] ? 40'd0 : counter_in;
      result.key_source          = (ctrl_in[4:3] == ash_pkg::MODE_DEFAULT) ?
                                   default_src_ff : keysrc_in;
      result.key_index           = key_index;
      result.total_header_length = len_in;
   end

endmodule

@@ hw/rtl/ash_out_reg.sv @@
// Result register of the auxiliary security header parser.
// Holds one finished result until the consumer takes it.
// Depends on ash_pkg.
module ash_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  ash_pkg::result_type load_data,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output ash_pkg::result_type rsp_data
);

   logic                valid_ff, valid_in;
   ash_pkg::result_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ hw/rtl/aux_security_header_parser.sv @@
// Auxiliary security header parser: one header byte per request, one result per complete header.
// A closing request is held in the input register, then its result in the result register.
// Throughput: one request per cycle if unstalled, set by input register and single parse update.
// A stalled result holds the parse update; the input stalls once its register is also full.
// Reset clears the parse state, the default key source and both valid flags.
// Depends on ash_pkg, ash_parse and ash_out_reg.
module aux_security_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_first_byte,
   input  logic [6:0]  req_header_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_security_level,
   output logic [4:0]  rsp_tag_length,
   output logic [1:0]  rsp_key_id_mode,
   output logic        rsp_counter_suppressed,
   output logic        rsp_counter_size_flag,
   output logic [39:0] rsp_frame_counter,
   output logic [63:0] rsp_key_source,
   output logic [7:0]  rsp_key_index,
   output logic [7:0]  rsp_total_header_length,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          byte_ff;
   logic                first_ff;
   logic [6:0]          offset_ff;
   logic                pipe_en;
   logic                accept;
   logic                go;
   logic                emit;
   ash_pkg::result_type result;
   ash_pkg::result_type rsp_data;

   assign pipe_en   = !(rsp_valid && rsp_stall);
   assign req_stall = in_valid_ff && !pipe_en;
   assign accept    = req_valid && !req_stall;
   assign go        = in_valid_ff && pipe_en;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (pipe_en) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff   <= req_in_byte;
         first_ff  <= req_first_byte;
         offset_ff <= req_header_offset;
      end
   end

   ash_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .go            (go),
      .in_byte       (byte_ff),
      .first_byte    (first_ff),
      .header_offset (offset_ff),
      .emit          (emit),
      .result        (result)
   );

   ash_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (go && emit),
      .load_data (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_security_level      = rsp_data.security_level;
   assign rsp_tag_length          = rsp_data.tag_length;
   assign rsp_key_id_mode         = rsp_data.key_id_mode;
   assign rsp_counter_suppressed  = rsp_data.counter_suppressed;
   assign rsp_counter_size_flag   = rsp_data.counter_size_flag;
   assign rsp_frame_counter       = rsp_data.frame_counter;
   assign rsp_key_source          = rsp_data.key_source;
   assign rsp_key_index           = rsp_data.key_index;
   assign rsp_total_header_length = rsp_data.total_header_length;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for aux_security_header_parser: random and directed header bytes,
// with an in-bench parser that predicts every header result and checks it field by field.
// Depends on ash_pkg and the aux_security_header_parser RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned CycleLimit = 60000;
   localparam int unsigned LongHold = 60;

   typedef struct {
      logic [7:0] data;
      logic       first;
      logic [6:0] offset;
   } header_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'd0;
   logic        req_first_byte = 1'b0;
   logic [6:0]  req_header_offset = 7'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_security_level;
   logic [4:0]  rsp_tag_length;
   logic [1:0]  rsp_key_id_mode;
   logic        rsp_counter_suppressed;
   logic        rsp_counter_size_flag;
   logic [39:0] rsp_frame_counter;
   logic [63:0] rsp_key_source;
   logic [7:0]  rsp_key_index;
   logic [7:0]  rsp_total_header_length;
   logic        csr_wr_en = 1'b0;
   logic [63:0] csr_wr_data = 64'd0;

   header_byte_type     pending_bytes[$];
   header_byte_type     next_byte;
   ash_pkg::result_type expected_headers[$];

   ash_pkg::phase_type parse_state = ash_pkg::PH_IDLE;
   int          byte_idx = 0;
   logic [6:0]  held_ctl = '0;
   logic [39:0] held_ctr = '0;
   logic [63:0] held_src = '0;
   logic [7:0]  run_len = '0;
   logic [63:0] default_source = '0;

   int unsigned queued_items = 0;
   int unsigned bytes_accepted = 0;
   int unsigned headers_checked = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   bit          hold_armed = 1'b0;
   bit          hold_done = 1'b0;
   bit          quiet = 1'b0;

   aux_security_header_parser u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_byte(req_in_byte),
      .req_first_byte(req_first_byte),
      .req_header_offset(req_header_offset),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_security_level(rsp_security_level),
      .rsp_tag_length(rsp_tag_length),
      .rsp_key_id_mode(rsp_key_id_mode),
      .rsp_counter_suppressed(rsp_counter_suppressed),
      .rsp_counter_size_flag(rsp_counter_size_flag),
      .rsp_frame_counter(rsp_frame_counter),
      .rsp_key_source(rsp_key_source),
      .rsp_key_index(rsp_key_index),
      .rsp_total_header_length(rsp_total_header_length),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic close_header(input logic [7:0] idx);
      ash_pkg::result_type r;
      r.security_level = held_ctl[2:0];
      case (held_ctl[1:0])
         2'd0: r.tag_length = 5'd0;
         2'd1: r.tag_length = 5'd4;
         2'd2: r.tag_length = 5'd8;
         default: r.tag_length = 5'd16;
      endcase
      r.key_id_mode = held_ctl[4:3];
      r.counter_suppressed = held_ctl[5];
      r.counter_size_flag = held_ctl[6];
      r.frame_counter = held_ctl[5] ? 40'd0 : held_ctr;
      r.key_source = (held_ctl[4:3] == ash_pkg::MODE_DEFAULT) ? default_source : held_src;
      r.key_index = idx;
      r.total_header_length = run_len;
      expected_headers.push_back(r);
      parse_state = ash_pkg::PH_IDLE;
      byte_idx = 0;
   endtask

   task automatic counter_settled();
      if (held_ctl[4:3] == ash_pkg::MODE_DEFAULT) begin
         close_header(ash_pkg::IMPLIED_KEY_INDEX);
      end else begin
         parse_state = ash_pkg::PH_KEYSRC;
         byte_idx = 0;
      end
   endtask

   task automatic parse_header_byte(input logic [7:0] b, input logic first,
                                    input logic [6:0] offs);
      int src_len;
      src_len = (held_ctl[4:3] == ash_pkg::MODE_SHORT) ?
                ash_pkg::ShortSourceBytes : ash_pkg::LongSourceBytes;
      if (first) begin
         held_ctl = b[6:0];
         held_ctr = '0;
         held_src = '0;
         byte_idx = 0;
         run_len = 8'(offs) + 8'd1;
         if (!b[5]) begin
            parse_state = ash_pkg::PH_COUNTER;
         end else begin
            counter_settled();
         end
      end else begin
         case (parse_state)
            ash_pkg::PH_COUNTER: begin
               held_ctr[8*byte_idx +: 8] = b;
               run_len = run_len + 8'd1;
               byte_idx++;
               if (byte_idx >= ash_pkg::CounterBytes) counter_settled();
            end
            ash_pkg::PH_KEYSRC: begin
               held_src[8*byte_idx +: 8] = b;
               run_len = run_len + 8'd1;
               if (byte_idx + 1 >= src_len) begin
                  parse_state = ash_pkg::PH_KEYIDX;
                  byte_idx = 0;
               end else begin
                  byte_idx++;
               end
            end
            ash_pkg::PH_KEYIDX: begin
               run_len = run_len + 8'd1;
               close_header(b);
            end
            default: ;
         endcase
      end
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // The monitor predicts on request acceptance before it checks results of the same edge.
   always @(posedge clock) begin
      ash_pkg::result_type want;
      if (reset) begin
         parse_state = ash_pkg::PH_IDLE;
         byte_idx = 0;
         held_ctl = '0;
         held_ctr = '0;
         held_src = '0;
         run_len = '0;
         default_source = '0;
      end else begin
         if (csr_wr_en) default_source = csr_wr_data;
         if (req_valid && !req_stall) begin
            parse_header_byte(req_in_byte, req_first_byte, req_header_offset);
            bytes_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_headers.size() == 0) begin
               mismatches++;
               $display("%0t: result with no header pending, expected none, actual key_source %0h",
                        $time, rsp_key_source);
            end else begin
               want = expected_headers.pop_front();
               compare_field("security_level", 64'(want.security_level), 64'(rsp_security_level));
               compare_field("tag_length", 64'(want.tag_length), 64'(rsp_tag_length));
               compare_field("key_id_mode", 64'(want.key_id_mode), 64'(rsp_key_id_mode));
               compare_field("counter_suppressed", 64'(want.counter_suppressed),
                             64'(rsp_counter_suppressed));
               compare_field("counter_size_flag", 64'(want.counter_size_flag),
                             64'(rsp_counter_size_flag));
               compare_field("frame_counter", 64'(want.frame_counter), 64'(rsp_frame_counter));
               compare_field("key_source", want.key_source, rsp_key_source);
               compare_field("key_index", 64'(want.key_index), 64'(rsp_key_index));
               compare_field("total_header_length", 64'(want.total_header_length),
                             64'(rsp_total_header_length));
            end
            headers_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0 || pending_bytes.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end else begin
            next_byte = pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_in_byte <= next_byte.data;
            req_first_byte <= next_byte.first;
            req_header_offset <= next_byte.offset;
            if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 3);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LongHold;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
                  expected_headers.size());
         $display("aux_security_header_parser test failed");
         $finish;
      end
   end

   task automatic add_byte(input logic [7:0] b, input logic first, input logic [6:0] offs);
      header_byte_type item;
      item.data = b;
      item.first = first;
      item.offset = offs;
      pending_bytes.push_back(item);
   endtask

   // A nonzero cut shorter than the header sends only the leading bytes of the header.
   task automatic add_header(input logic [7:0] ctl, input logic [6:0] offs,
                             input logic [39:0] ctr, input logic [63:0] src,
                             input logic [7:0] idx, input int cut);
      logic [7:0] seq[$];
      int n;
      seq.push_back(ctl);
      if (!ctl[5]) begin
         for (int i = 0; i < ash_pkg::CounterBytes; i++) seq.push_back(ctr[8*i +: 8]);
      end
      if (ctl[4:3] == ash_pkg::MODE_DEFAULT) n = 0;
      else if (ctl[4:3] == ash_pkg::MODE_SHORT) n = ash_pkg::ShortSourceBytes;
      else n = ash_pkg::LongSourceBytes;
      for (int i = 0; i < n; i++) seq.push_back(src[8*i +: 8]);
      if (ctl[4:3] != ash_pkg::MODE_DEFAULT) seq.push_back(idx);
      n = (cut > 0 && cut < seq.size()) ? cut : seq.size();
      for (int i = 0; i < n; i++)
         add_byte(seq[i], i == 0, (i == 0) ? offs : 7'($urandom_range(0, 127)));
      queued_items += n;
   endtask

   task automatic random_header();
      int pick;
      logic [6:0] offs;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) offs = $urandom_range(0, 1) ? 7'd127 : 7'd0;
      else offs = 7'($urandom_range(0, 127));
      if (pick < 6) begin
         repeat ($urandom_range(1, 2)) add_byte(8'($urandom), 1'b0, 7'($urandom));
      end else begin
         add_header(8'($urandom), offs, {8'($urandom), 32'($urandom)}, {$urandom, $urandom},
                    8'($urandom), (pick < 18) ? $urandom_range(1, 14) : 0);
         if (pick < 18)
            add_header(8'($urandom), 7'($urandom), {8'($urandom), 32'($urandom)},
                       {$urandom, $urandom}, 8'($urandom), 0);
      end
   endtask

   task automatic run_random(input int unsigned target);
      while (queued_items < target) random_header();
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_headers.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_default_source(input logic [63:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_byte(8'hFF, 1'b0, 7'h7F);
      add_header(8'h20, 7'd0, 40'd0, 64'd0, 8'd0, 0);
      add_header(8'hE7, 7'd127, 40'd0, 64'd0, 8'd0, 0);
      add_header(8'h0B, 7'd20, 40'd0, 64'd0, 8'd0, 3);
      add_header(8'h36, 7'd64, 40'd0, 64'h0000_0000_0000_A55A, 8'h00, 0);
      add_header(8'h58, 7'd127, 40'hFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 0);
      drain();

      load_default_source(64'hFFFF_FFFF_FFFF_FFFF);
      run_random(150);
      add_header(8'($urandom), 7'($urandom), 40'd0, {$urandom, $urandom}, 8'($urandom), 0);
      drain();

      load_default_source({$urandom, $urandom});
      hold_armed = 1'b1;
      run_random(275);
      add_header(8'($urandom), 7'($urandom), 40'd0, {$urandom, $urandom}, 8'($urandom), 0);
      drain();

      load_default_source(64'd0);
      quiet = 1'b1;
      run_random(400);
      add_header(8'($urandom), 7'($urandom), 40'd0, {$urandom, $urandom}, 8'($urandom), 0);
      drain();

      $display("Checked %0d header results from %0d request bytes under four key source values.",
               headers_checked, bytes_accepted);
      $display("Stimulus mixed all key id modes, cut and idle bytes and a long receiver hold.");
      if (mismatches == 0 && expected_headers.size() == 0) begin
         $display("aux_security_header_parser test passed");
      end else begin
         $display("aux_security_header_parser test failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/ash_pkg.sv
hw/rtl/ash_parse.sv
hw/rtl/ash_out_reg.sv
hw/rtl/aux_security_header_parser.sv
verif/testbench.sv
